// ===== src/fbid_pkg.sv =====
package fbid_pkg;

  localparam int FBID_NUM_DIGITS = 6;
  localparam int FBID_MID_DEPTH  = 4;
  localparam int FBID_OUT_DEPTH  = 4;

  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

  // floor(2^35 / 31); quotient by 62 is (v >> 1) * RECIP >> 35, low by at most one
  localparam logic [30:0] B62_RECIP = 31'd1108378657;
  localparam int          B62_SHIFT = 35;
  localparam int          B62_PRODW = 62;
  localparam int          B62_QW    = 27;
  localparam logic [6:0]  B62_RADIX = 7'd62;

  typedef logic [6:0] digit_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [63:0] full_hash;
    logic [31:0] folded_hash;
    digit_t      digit_0;
    digit_t      digit_1;
    digit_t      digit_2;
    digit_t      digit_3;
    digit_t      digit_4;
    digit_t      digit_5;
  } out_req_t;

  typedef struct packed {
    logic [63:0]                         full_hash;
    logic [31:0]                         folded;
    logic [31:0]                         val;
    logic [B62_PRODW-1:0]                prod;
    logic [FBID_NUM_DIGITS-1:0][6:0]     digits;
  } b62_stg_t;

  function automatic digit_t b62_char(input logic [5:0] r);
    digit_t c;
    if (r < 6'd10) begin
      c = 7'd48 + 7'(r);
    end else if (r < 6'd36) begin
      c = 7'd55 + 7'(r);
    end else begin
      c = 7'd61 + 7'(r);
    end
    return c;
  endfunction

endpackage

// ===== src/fbid_fifo.sv =====
module fbid_fifo #(
  parameter int  DEPTH = 4,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output T     rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          wr_en, rd_en;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/fbid_hash.sv =====
module fbid_hash (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  fbid_pkg::in_req_t in_req,
  output logic             in_full,
  input  logic             mid_full,
  output logic             mid_push,
  output logic [63:0]      mid_hash
);

  import fbid_pkg::*;

  logic [63:0] hash_r, hash_nxt;
  logic [63:0] x;
  logic [63:0] h_upd;
  logic        accept;

  // x * 0x100000001B3 = x << 40 + x * 0x1B3
  assign x      = hash_r ^ {56'd0, in_req.data_byte};
  assign h_upd  = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  assign accept = in_push && !mid_full;

  assign in_full  = mid_full;
  assign mid_push = accept && in_req.last_byte;
  assign mid_hash = h_upd;

  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = in_req.last_byte ? FNV_BASIS : h_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// ===== src/fbid_b62.sv =====
module fbid_b62 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [63:0]        in_hash,
  output logic               in_ready,
  output logic               out_valid,
  output fbid_pkg::out_req_t out_req,
  input  logic               out_ready
);

  import fbid_pkg::*;

  localparam int ND = FBID_NUM_DIGITS;

  b62_stg_t a_r [ND];
  b62_stg_t b_r [ND];
  b62_stg_t a_nxt [ND];
  b62_stg_t b_nxt [ND];
  logic [ND-1:0] a_v_r, b_v_r;
  logic          adv;

  assign adv      = !b_v_r[ND-1] || out_ready;
  assign in_ready = adv;

  // per digit: stage a multiplies by the reciprocal, stage b corrects and emits
  always_comb begin
    b62_stg_t          src;
    logic [B62_QW-1:0] q0;
    logic [B62_QW-1:0] q;
    logic [32:0]       t;
    logic [32:0]       r_w;
    logic [6:0]        r;
    for (int k = 0; k < ND; k++) begin
      if (k == 0) begin
        src.full_hash = in_hash;
        src.folded    = in_hash[31:0] ^ in_hash[63:32];
        src.val       = in_hash[31:0] ^ in_hash[63:32];
        src.prod      = '0;
        src.digits    = '0;
      end else begin
        src = b_r[k-1];
      end
      a_nxt[k]      = src;
      a_nxt[k].prod = src.val[31:1] * B62_RECIP;

      q0  = a_r[k].prod[B62_SHIFT +: B62_QW];
      t   = {q0, 6'd0} - 33'({q0, 1'b0});
      r_w = {1'b0, a_r[k].val} - t;
      r   = r_w[6:0];
      q   = q0;
      if (r >= B62_RADIX) begin
        r = r - B62_RADIX;
        q = q0 + 1'b1;
      end
      b_nxt[k]                 = a_r[k];
      b_nxt[k].val             = 32'(q);
      b_nxt[k].digits[ND-1-k]  = b62_char(r[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= '0;
      b_v_r <= '0;
    end else if (adv) begin
      a_v_r <= {b_v_r[ND-2:0], in_valid};
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ND; k++) begin
        a_r[k] <= a_nxt[k];
        b_r[k] <= b_nxt[k];
      end
    end
  end

  assign out_valid           = b_v_r[ND-1];
  assign out_req.full_hash   = b_r[ND-1].full_hash;
  assign out_req.folded_hash = b_r[ND-1].folded;
  assign out_req.digit_0     = b_r[ND-1].digits[0];
  assign out_req.digit_1     = b_r[ND-1].digits[1];
  assign out_req.digit_2     = b_r[ND-1].digits[2];
  assign out_req.digit_3     = b_r[ND-1].digits[3];
  assign out_req.digit_4     = b_r[ND-1].digits[4];
  assign out_req.digit_5     = b_r[ND-1].digits[5];

endmodule

// ===== src/fnv1a64_base62_id_top.sv =====
// FNV-1a 64-bit hash with a six-digit base-62 tag. Push one message byte per request,
// with last_byte set on the final byte; each message yields one result holding the full
// hash, its 32-bit XOR fold and six ASCII base-62 digits (0-9, A-Z, a-z) of the fold
// modulo 62^6, most significant first. Input rate is one byte per cycle while the
// middle queue is not full, set by the combinational hash update (XOR plus a
// constant multiply folded into shifts and adds). Finished hashes pass through a
// MID_DEPTH-entry queue into a 12-stage digit pipeline (two stages per digit:
// reciprocal multiply, then correct) that takes one hash per cycle while the result
// queue has room, then into an OUT_DEPTH-entry result queue. in_full only rises
// when the middle queue is full because results are not being popped.
module fnv1a64_base62_id_top #(
  parameter int MID_DEPTH = fbid_pkg::FBID_MID_DEPTH,
  parameter int OUT_DEPTH = fbid_pkg::FBID_OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  fbid_pkg::in_req_t  in_req,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output fbid_pkg::out_req_t out_req
);

  import fbid_pkg::*;

  logic        mid_push, mid_full, mid_empty, mid_pop;
  logic [63:0] mid_hash, mid_head;
  logic        b62_ready, b62_valid, res_full;
  out_req_t    b62_req;

  fbid_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_req   (in_req),
    .in_full  (in_full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_hash (mid_hash)
  );

  fbid_fifo #(.DEPTH(MID_DEPTH), .T(logic [63:0])) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_hash),
    .full  (mid_full),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_head)
  );

  assign mid_pop = !mid_empty && b62_ready;

  fbid_b62 u_b62 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!mid_empty),
    .in_hash   (mid_head),
    .in_ready  (b62_ready),
    .out_valid (b62_valid),
    .out_req   (b62_req),
    .out_ready (!res_full)
  );

  fbid_fifo #(.DEPTH(OUT_DEPTH), .T(out_req_t)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b62_valid),
    .wdata (b62_req),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_req)
  );

endmodule

// ===== src/fbid_chk.sv =====
module fbid_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_pop,
  input logic               out_empty,
  input fbid_pkg::out_req_t out_req
);

  import fbid_pkg::*;

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_req.folded_hash == (out_req.full_hash[31:0] ^ out_req.full_hash[63:32]))
    else $error("folded hash does not match full hash");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      ((out_req.digit_0 >= 7'd48 && out_req.digit_0 <= 7'd57) ||
       (out_req.digit_0 >= 7'd65 && out_req.digit_0 <= 7'd90) ||
       (out_req.digit_0 >= 7'd97 && out_req.digit_0 <= 7'd122)) &&
      ((out_req.digit_5 >= 7'd48 && out_req.digit_5 <= 7'd57) ||
       (out_req.digit_5 >= 7'd65 && out_req.digit_5 <= 7'd90) ||
       (out_req.digit_5 >= 7'd97 && out_req.digit_5 <= 7'd122)))
    else $error("digit outside base-62 alphabet");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_req))
    else $error("waiting result changed");

endmodule

bind fnv1a64_base62_id_top fbid_chk u_fbid_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_req   (out_req)
);
